>>> hdl/one_wire_bus_master_macros.svh
// Assertion macros used by the one-wire bus master sequencer RTL.
`ifndef ONE_WIRE_BUS_MASTER_MACROS_SVH
`define ONE_WIRE_BUS_MASTER_MACROS_SVH

// Same-cycle implication, checked on clk, off while rst_n is low.
`define OWBM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked on clk, off while rst_n is low.
`define OWBM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> hdl/owbm_pkg.sv
// Types and constants shared by the one-wire bus master modules.
`default_nettype none

package owbm_pkg;

  // Beat kinds on the input channel
  localparam logic [2:0] KIND_TICK  = 3'd0;
  localparam logic [2:0] KIND_RESET = 3'd1;
  localparam logic [2:0] KIND_WBIT  = 3'd2;
  localparam logic [2:0] KIND_RBIT  = 3'd3;
  localparam logic [2:0] KIND_WBYTE = 3'd4;
  localparam logic [2:0] KIND_RBYTE = 3'd5;

  // Sequencer phases
  localparam logic [2:0] PH_IDLE     = 3'd0;
  localparam logic [2:0] PH_RST_LOW  = 3'd1;
  localparam logic [2:0] PH_RST_WAIT = 3'd2;
  localparam logic [2:0] PH_RST_TAIL = 3'd3;
  localparam logic [2:0] PH_SLOT     = 3'd4;

  // Configuration register indexes
  localparam logic [2:0] REG_RESET_LOW     = 3'd0;
  localparam logic [2:0] REG_PRESENCE_WAIT = 3'd1;
  localparam logic [2:0] REG_RESET_TAIL    = 3'd2;
  localparam logic [2:0] REG_SHORT_LOW     = 3'd3;
  localparam logic [2:0] REG_LONG_LOW      = 3'd4;
  localparam logic [2:0] REG_READ_SAMPLE   = 3'd5;
  localparam logic [2:0] REG_SLOT_LEN      = 3'd6;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 10;

  // Timing register reset values (microseconds)
  localparam logic [9:0] RESET_LOW_DEF     = 10'd480;
  localparam logic [9:0] PRESENCE_WAIT_DEF = 10'd70;
  localparam logic [9:0] RESET_TAIL_DEF    = 10'd410;
  localparam logic [5:0] SHORT_LOW_DEF     = 6'd6;
  localparam logic [6:0] LONG_LOW_DEF      = 7'd60;
  localparam logic [5:0] READ_SAMPLE_DEF   = 6'd9;
  localparam logic [7:0] SLOT_LEN_DEF      = 8'd70;

  typedef struct packed {
    logic [9:0] reset_low_us;
    logic [9:0] presence_wait_us;
    logic [9:0] reset_tail_us;
    logic [5:0] short_low_us;
    logic [6:0] long_low_us;
    logic [5:0] read_sample_us;
    logic [7:0] slot_len_us;
  } cfg_t;

  typedef struct packed {
    logic       drive_low;
    logic       busy_res;
    logic       done_res;
    logic       presence;
    logic [7:0] read_data;
    logic       rejected;
  } res_t;

endpackage

`default_nettype wire

>>> hdl/one_wire_bus_master.sv
// One-wire bus master top level: input beat register, sequencer and result register.
//
// The block takes one beat per clock cycle, back to back, unless a channel stalls:
// each beat is either a one-microsecond tick or a command (reset, write bit, read
// bit, write byte, read byte), and gives exactly one result beat with the line
// drive, busy, done, presence, read data and rejected flags after that beat. A beat
// is latched into an input register, stepped through the sequencer and lands in a
// result register; the single sequencer step per cycle sets the rate of one beat
// per cycle while the result channel is not stalled. Both channels stall cleanly
// under backpressure. Timing registers are written through the cfg_ port; the user
// must write them only while the block is idle, which the block does not enforce.
`default_nettype none

module one_wire_bus_master (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  // input channel
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  input  wire logic [15:0]                     in_tdata,  // [7:0] write_data, [8] line_level
  input  wire logic [2:0]                      in_tuser,  // [2:0] kind
  // result channel
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  output logic [15:0]                          out_tdata, // [0] drive_low, [1] busy_res,
                                                          // [2] done_res, [3] presence,
                                                          // [11:4] read_data, [12] rejected
  // configuration
  input  wire logic                            cfg_we,
  input  wire logic [owbm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [owbm_pkg::CFG_DATA_W-1:0] cfg_data
);
  import owbm_pkg::*;

  cfg_t       cfg;
  res_t       res;
  logic       proceed;

  // Input beat register
  logic       in_valid_r;
  logic [2:0] kind_r;
  logic [7:0] wdata_r;
  logic       level_r;

  // Result register
  logic       out_valid_r, out_valid_nxt;
  res_t       res_r;

  assign proceed   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || proceed;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      kind_r  <= in_tuser;
      wdata_r <= in_tdata[7:0];
      level_r <= in_tdata[8];
    end
  end

  owbm_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  owbm_engine u_engine (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (proceed),
    .kind       (kind_r),
    .write_data (wdata_r),
    .line_level (level_r),
    .cfg        (cfg),
    .res        (res)
  );

  // Result beat holds until taken
  always_comb begin
    if (proceed)         out_valid_nxt = 1'b1;
    else if (out_tready) out_valid_nxt = 1'b0;
    else                 out_valid_nxt = out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (proceed) res_r <= res;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, res_r.rejected, res_r.read_data, res_r.presence,
                       res_r.done_res, res_r.busy_res, res_r.drive_low};

endmodule

`default_nettype wire

>>> hdl/owbm_cfg.sv
// Timing configuration registers of the one-wire bus master.
`default_nettype none

module owbm_cfg (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_we,
  input  wire logic [owbm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [owbm_pkg::CFG_DATA_W-1:0] cfg_data,
  output owbm_pkg::cfg_t                       cfg
);
  import owbm_pkg::*;

  cfg_t cfg_r, cfg_nxt;

  // Write decode; unknown indexes are dropped
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        REG_RESET_LOW:     cfg_nxt.reset_low_us     = cfg_data;
        REG_PRESENCE_WAIT: cfg_nxt.presence_wait_us = cfg_data;
        REG_RESET_TAIL:    cfg_nxt.reset_tail_us    = cfg_data;
        REG_SHORT_LOW:     cfg_nxt.short_low_us     = cfg_data[5:0];
        REG_LONG_LOW:      cfg_nxt.long_low_us      = cfg_data[6:0];
        REG_READ_SAMPLE:   cfg_nxt.read_sample_us   = cfg_data[5:0];
        REG_SLOT_LEN:      cfg_nxt.slot_len_us      = cfg_data[7:0];
        default:           cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.reset_low_us     <= RESET_LOW_DEF;
      cfg_r.presence_wait_us <= PRESENCE_WAIT_DEF;
      cfg_r.reset_tail_us    <= RESET_TAIL_DEF;
      cfg_r.short_low_us     <= SHORT_LOW_DEF;
      cfg_r.long_low_us      <= LONG_LOW_DEF;
      cfg_r.read_sample_us   <= READ_SAMPLE_DEF;
      cfg_r.slot_len_us      <= SLOT_LEN_DEF;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

>>> hdl/owbm_engine.sv
// Bus sequencer state and single-beat step logic of the one-wire bus master.
`default_nettype none

module owbm_engine (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       step,
  input  wire logic [2:0] kind,
  input  wire logic [7:0] write_data,
  input  wire logic       line_level,
  input  wire owbm_pkg::cfg_t cfg,
  output owbm_pkg::res_t  res
);
  import owbm_pkg::*;

  logic [2:0] phase_r, phase_nxt;
  logic [2:0] op_r, op_nxt;
  logic [9:0] count_r, count_nxt;
  logic [3:0] bits_r, bits_nxt;
  logic [7:0] shift_r, shift_nxt;
  logic       pres_r, pres_nxt;
  logic       pulled_r, pulled_nxt;
  logic       done, rej;
  logic [7:0] rdata;

  // Slot timing derived from the current bit
  logic       op_read, op_write;
  logic [9:0] count_inc;
  logic [7:0] slot_len, sample_at, sample_sum;
  logic [6:0] low_time;

  always_comb begin
    op_read    = (op_r == KIND_RBIT) || (op_r == KIND_RBYTE);
    op_write   = (op_r == KIND_WBIT) || (op_r == KIND_WBYTE);
    count_inc  = count_r + 10'd1;
    slot_len   = (cfg.slot_len_us == 8'd0) ? 8'd1 : cfg.slot_len_us;
    low_time   = (op_write && !shift_r[0]) ? cfg.long_low_us : {1'b0, cfg.short_low_us};
    sample_sum = {1'b0, low_time} + {2'b00, cfg.read_sample_us};
    sample_at  = (sample_sum > slot_len) ? slot_len : sample_sum;
    if (sample_at == 8'd0) sample_at = 8'd1;
  end

  // Next state for one beat
  always_comb begin
    phase_nxt  = phase_r;
    op_nxt     = op_r;
    count_nxt  = count_r;
    bits_nxt   = bits_r;
    shift_nxt  = shift_r;
    pres_nxt   = pres_r;
    pulled_nxt = pulled_r;
    done       = 1'b0;
    rej        = 1'b0;
    rdata      = 8'd0;
    if (kind == KIND_TICK) begin
      if (phase_r != PH_IDLE) begin
        count_nxt = count_inc;
        unique case (phase_r)
          PH_RST_LOW: begin
            if (count_inc >= cfg.reset_low_us) begin
              pulled_nxt = 1'b0;
              phase_nxt  = PH_RST_WAIT;
              count_nxt  = 10'd0;
            end
          end
          PH_RST_WAIT: begin
            if (count_inc >= cfg.presence_wait_us) begin
              pres_nxt  = !line_level;
              count_nxt = 10'd0;
              if (cfg.reset_tail_us == 10'd0) begin
                phase_nxt = PH_IDLE;
                done      = 1'b1;
              end else begin
                phase_nxt = PH_RST_TAIL;
              end
            end
          end
          PH_RST_TAIL: begin
            if (count_inc >= cfg.reset_tail_us) begin
              phase_nxt = PH_IDLE;
              done      = 1'b1;
            end
          end
          PH_SLOT: begin
            pulled_nxt = count_inc < {3'b000, low_time};
            // Read sample point
            if (op_read && count_inc == {2'b00, sample_at}) begin
              if (op_r == KIND_RBIT) shift_nxt = {7'd0, line_level};
              else                   shift_nxt = {line_level, shift_r[7:1]};
            end
            // Slot end
            if (count_inc >= {2'b00, slot_len}) begin
              if (!op_read) shift_nxt = {1'b0, shift_r[7:1]};
              bits_nxt  = bits_r - 4'd1;
              count_nxt = 10'd0;
              if (bits_r == 4'd1) begin
                pulled_nxt = 1'b0;
                phase_nxt  = PH_IDLE;
                done       = 1'b1;
              end else begin
                pulled_nxt = 1'b1;
              end
            end
          end
          default: phase_nxt = PH_IDLE;
        endcase
        if (done && op_read) rdata = shift_nxt;
      end
    end else if (kind <= KIND_RBYTE) begin
      if (phase_r != PH_IDLE) begin
        rej = 1'b1;
      end else begin
        op_nxt     = kind;
        count_nxt  = 10'd0;
        pulled_nxt = 1'b1;
        if (kind == KIND_RESET) begin
          phase_nxt = PH_RST_LOW;
          bits_nxt  = 4'd0;
        end else begin
          phase_nxt = PH_SLOT;
          bits_nxt  = (kind == KIND_WBIT || kind == KIND_RBIT) ? 4'd1 : 4'd8;
          unique case (kind)
            KIND_WBIT:  shift_nxt = {7'd0, write_data[0]};
            KIND_WBYTE: shift_nxt = write_data;
            default:    shift_nxt = 8'd0;
          endcase
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_IDLE;
      op_r     <= 3'd0;
      count_r  <= 10'd0;
      bits_r   <= 4'd0;
      shift_r  <= 8'd0;
      pres_r   <= 1'b0;
      pulled_r <= 1'b0;
    end else if (step) begin
      phase_r  <= phase_nxt;
      op_r     <= op_nxt;
      count_r  <= count_nxt;
      bits_r   <= bits_nxt;
      shift_r  <= shift_nxt;
      pres_r   <= pres_nxt;
      pulled_r <= pulled_nxt;
    end
  end

  // Result of this beat, as seen after the update
  always_comb begin
    res.drive_low = pulled_nxt;
    res.busy_res  = phase_nxt != PH_IDLE;
    res.done_res  = done;
    res.presence  = pres_nxt;
    res.read_data = rdata;
    res.rejected  = rej;
  end

`include "one_wire_bus_master_macros.svh"

  `OWBM_ASSERT_NOW(a_idle_released, phase_r == PH_IDLE, !pulled_r, "line pulled while idle")
  `OWBM_ASSERT_NOW(a_slot_has_bits, phase_r == PH_SLOT, bits_r != 4'd0, "slot with no bits left")
  `OWBM_ASSERT_NOW(a_bits_range, 1'b1, bits_r <= 4'd8, "bit count out of range")
  `OWBM_ASSERT_NEXT(a_done_idles, step && done, phase_r == PH_IDLE, "done without going idle")
  `OWBM_ASSERT_NOW(a_done_not_rej, 1'b1, !(done && rej), "done and rejected together")

endmodule

`default_nettype wire

>>> bench/one_wire_bus_master_tb.sv
// Testbench for the one-wire bus master: random and directed beats checked against a predictor.
module one_wire_bus_master_tb;
  import owbm_pkg::*;

  // Kinds the block ignores
  localparam logic [2:0] KIND_SPARE6 = 3'd6;
  localparam logic [2:0] KIND_SPARE7 = 3'd7;

  localparam int CYCLE_LIMIT = 400000;
  localparam int MAX_PRINTED = 50;
  localparam int HOLD_CYCLES = 300;

  typedef struct {
    logic [2:0] kind;
    logic [7:0] wdata;
    logic       level;
  } beat_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = '0;
  logic [2:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;
  logic        cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  one_wire_bus_master i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),   // [7:0] write_data, [8] line_level
    .in_tuser   (in_tuser),   // [2:0] kind
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),  // [0] drive_low, [1] busy_res, [2] done_res, [3] presence,
                              // [11:4] read_data, [12] rejected
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // Beats waiting to be sent, results due back
  beat_t cmd_queue[$];
  res_t  due_results[$];
  beat_t cur_beat;
  int    beats_pushed = 0;
  int    beats_taken = 0;
  int    results_seen = 0;
  int    fail_count = 0;
  int    cycle_count = 0;
  int    idle_mode = 0;     // 0: sender 37 / receiver 57, 1: swapped, 2: no idling
  logic  stall_req = 1'b0;
  logic  stall_done = 1'b0;
  int    hold_left = 0;

  // Predictor state and timing registers
  cfg_t       ow_cfg = '{reset_low_us: RESET_LOW_DEF, presence_wait_us: PRESENCE_WAIT_DEF,
                         reset_tail_us: RESET_TAIL_DEF, short_low_us: SHORT_LOW_DEF,
                         long_low_us: LONG_LOW_DEF, read_sample_us: READ_SAMPLE_DEF,
                         slot_len_us: SLOT_LEN_DEF};
  logic [2:0] ow_phase = PH_IDLE;
  logic [2:0] ow_op = '0;
  logic [9:0] ow_us = '0;
  logic [3:0] ow_bits = '0;
  logic [7:0] ow_shift = '0;
  logic       ow_presence = 1'b0;
  logic       ow_pulled = 1'b0;

  // Clock
  initial begin
    forever #2 clk = ~clk;
  end

  function automatic bit read_op();
    return ow_op == KIND_RBIT || ow_op == KIND_RBYTE;
  endfunction

  // One microsecond of bus time; returns 1 when the operation ends on it
  function automatic bit advance_us(input logic level);
    int unsigned len, low, at;
    ow_us = ow_us + 10'd1;
    case (ow_phase)
      PH_RST_LOW: begin
        if (ow_us >= ow_cfg.reset_low_us) begin
          ow_pulled = 1'b0;
          ow_phase  = PH_RST_WAIT;
          ow_us     = '0;
        end
      end
      PH_RST_WAIT: begin
        if (ow_us >= ow_cfg.presence_wait_us) begin
          ow_presence = ~level;
          ow_us       = '0;
          if (ow_cfg.reset_tail_us == 0) begin
            ow_phase = PH_IDLE;
            return 1'b1;
          end
          ow_phase = PH_RST_TAIL;
        end
      end
      PH_RST_TAIL: begin
        if (ow_us >= ow_cfg.reset_tail_us) begin
          ow_phase = PH_IDLE;
          return 1'b1;
        end
      end
      PH_SLOT: begin
        len = (ow_cfg.slot_len_us != 0) ? ow_cfg.slot_len_us : 1;
        // a written zero holds the line for the long time
        low = ((ow_op == KIND_WBIT || ow_op == KIND_WBYTE) && !ow_shift[0]) ?
              ow_cfg.long_low_us : ow_cfg.short_low_us;
        at = low + ow_cfg.read_sample_us;
        if (at > len) at = len;
        if (at == 0) at = 1;
        ow_pulled = (ow_us < low);
        if (read_op() && ow_us == at) begin
          if (ow_op == KIND_RBIT) ow_shift = {7'd0, level};
          else ow_shift = {level, ow_shift[7:1]};
        end
        if (ow_us >= len) begin
          ow_pulled = 1'b0;
          if (!read_op()) ow_shift = ow_shift >> 1;
          ow_bits = ow_bits - 4'd1;
          ow_us   = '0;
          if (ow_bits == 0) begin
            ow_phase = PH_IDLE;
            return 1'b1;
          end
          ow_pulled = 1'b1;
        end
      end
      default: ow_phase = PH_IDLE;
    endcase
    return 1'b0;
  endfunction

  // Expected result of one accepted beat
  function automatic res_t bus_master_step(input beat_t b);
    res_t r;
    r = '0;
    if (b.kind == KIND_TICK) begin
      if (ow_phase != PH_IDLE && advance_us(b.level)) begin
        r.done_res = 1'b1;
        if (read_op()) r.read_data = ow_shift;
      end
    end else if (b.kind <= KIND_RBYTE) begin
      if (ow_phase != PH_IDLE) begin
        r.rejected = 1'b1;
      end else begin
        ow_op     = b.kind;
        ow_us     = '0;
        ow_pulled = 1'b1;
        if (b.kind == KIND_RESET) begin
          ow_phase = PH_RST_LOW;
          ow_bits  = '0;
        end else begin
          ow_phase = PH_SLOT;
          ow_bits  = (b.kind == KIND_WBIT || b.kind == KIND_RBIT) ? 4'd1 : 4'd8;
          case (b.kind)
            KIND_WBIT:  ow_shift = {7'd0, b.wdata[0]};
            KIND_WBYTE: ow_shift = b.wdata;
            default:    ow_shift = '0;
          endcase
        end
      end
    end
    r.drive_low = ow_pulled;
    r.busy_res  = (ow_phase != PH_IDLE);
    r.presence  = ow_presence;
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    if (fail_count < MAX_PRINTED) $display("MISMATCH at cycle %0d: %s", cycle_count, msg);
    fail_count++;
  endtask

  task automatic check_field(input string name, input int got, input int want);
    if (got != want) report_mismatch($sformatf("%s got %0d want %0d", name, got, want));
  endtask

  // Sender: drives beats from the queue, predicts each accepted beat
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        due_results.push_back(bus_master_step(cur_beat));
        beats_taken++;
      end
      if (!in_tvalid || in_tready) begin
        if (cmd_queue.size() != 0 &&
            $urandom_range(99) >= ((idle_mode == 0) ? 37 : (idle_mode == 1) ? 57 : 0)) begin
          cur_beat = cmd_queue.pop_front();
          in_tvalid <= 1'b1;
          in_tuser  <= cur_beat.kind;
          in_tdata  <= {7'd0, cur_beat.level, cur_beat.wdata};
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: checks result beats, stalls at random and once for a long stretch
  always @(posedge clk) begin
    res_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (due_results.size() == 0) begin
          report_mismatch($sformatf("result beat 0x%04h with nothing due", out_tdata));
        end else begin
          want = due_results.pop_front();
          check_field("drive_low", int'(out_tdata[0]), int'(want.drive_low));
          check_field("busy", int'(out_tdata[1]), int'(want.busy_res));
          check_field("done", int'(out_tdata[2]), int'(want.done_res));
          check_field("presence", int'(out_tdata[3]), int'(want.presence));
          check_field("read_data", int'(out_tdata[11:4]), int'(want.read_data));
          check_field("rejected", int'(out_tdata[12]), int'(want.rejected));
        end
        results_seen++;
      end
      if (stall_req && !stall_done) begin
        hold_left  = HOLD_CYCLES;
        stall_done = 1'b1;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(99) >=
                       ((idle_mode == 0) ? 57 : (idle_mode == 1) ? 37 : 0));
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("one_wire_bus_master test failed");
      $finish;
    end
  end

  task automatic push_beat(input logic [2:0] kind, input logic [7:0] wdata);
    beat_t b;
    b.kind  = kind;
    b.wdata = wdata;
    b.level = 1'($urandom_range(1));
    cmd_queue.push_back(b);
    beats_pushed++;
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (!(beats_taken == beats_pushed && results_seen == beats_taken));
  endtask

  // Tick until the running operation is over and every result is back
  task automatic finish_op();
    wait_drained();
    while (ow_phase != PH_IDLE) begin
      repeat (16) push_beat(KIND_TICK, 8'($urandom_range(255)));
      wait_drained();
    end
  endtask

  task automatic write_reg(input logic [2:0] idx, input int val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val[CFG_DATA_W-1:0];
    case (idx)
      REG_RESET_LOW:     ow_cfg.reset_low_us     = val[9:0];
      REG_PRESENCE_WAIT: ow_cfg.presence_wait_us = val[9:0];
      REG_RESET_TAIL:    ow_cfg.reset_tail_us    = val[9:0];
      REG_SHORT_LOW:     ow_cfg.short_low_us     = val[5:0];
      REG_LONG_LOW:      ow_cfg.long_low_us      = val[6:0];
      REG_READ_SAMPLE:   ow_cfg.read_sample_us   = val[5:0];
      default:           ow_cfg.slot_len_us      = val[7:0];
    endcase
  endtask

  task automatic set_timing(input int rst_low, input int pres_wait, input int tail,
                            input int short_low, input int long_low, input int sample,
                            input int slot);
    write_reg(REG_RESET_LOW, rst_low);
    write_reg(REG_PRESENCE_WAIT, pres_wait);
    write_reg(REG_RESET_TAIL, tail);
    write_reg(REG_SHORT_LOW, short_low);
    write_reg(REG_LONG_LOW, long_low);
    write_reg(REG_READ_SAMPLE, sample);
    write_reg(REG_SLOT_LEN, slot);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic random_timing();
    set_timing($urandom_range(1, 24), $urandom_range(1, 12), $urandom_range(0, 16),
               $urandom_range(1, 12), $urandom_range(1, 30), $urandom_range(1, 12),
               $urandom_range(2, 32));
  endtask

  // Mostly ticks, some commands (many land while busy), a few ignored kinds
  task automatic random_beats(input int n);
    int roll;
    repeat (n) begin
      roll = $urandom_range(99);
      if (roll < 75) push_beat(KIND_TICK, 8'($urandom_range(255)));
      else if (roll < 95) push_beat(3'($urandom_range(KIND_RESET, KIND_RBYTE)),
                                    8'($urandom_range(255)));
      else push_beat(3'($urandom_range(KIND_SPARE6, KIND_SPARE7)), 8'($urandom_range(255)));
    end
    finish_op();
  endtask

  // Stimulus
  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // reset values of the slot timing registers
    push_beat(KIND_WBIT, 8'hFE);
    finish_op();
    push_beat(KIND_RBIT, 8'h00);
    finish_op();

    // directed: zero reset tail, low time past slot end, late read sample
    set_timing(3, 2, 0, 2, 6, 5, 4);
    push_beat(KIND_TICK, 8'h00);
    push_beat(KIND_SPARE6, 8'hFF);
    push_beat(KIND_SPARE7, 8'h00);
    push_beat(KIND_WBIT, 8'h00);
    push_beat(KIND_RESET, 8'hFF);
    push_beat(KIND_SPARE6, 8'h00);
    push_beat(KIND_SPARE7, 8'hFF);
    finish_op();
    push_beat(KIND_WBIT, 8'hFF);
    finish_op();
    push_beat(KIND_RBIT, 8'h00);
    finish_op();
    push_beat(KIND_WBYTE, 8'hA5);
    push_beat(KIND_RBYTE, 8'h00);
    finish_op();
    push_beat(KIND_WBYTE, 8'h00);
    finish_op();
    push_beat(KIND_WBYTE, 8'hFF);
    finish_op();
    push_beat(KIND_RBYTE, 8'h5A);
    finish_op();
    push_beat(KIND_RESET, 8'h00);
    push_beat(KIND_WBYTE, 8'h3C);
    push_beat(KIND_RBIT, 8'h00);
    finish_op();

    // smallest timings
    set_timing(1, 1, 0, 1, 1, 1, 2);
    random_beats(80);

    idle_mode = 1;
    random_timing();
    random_beats(100);

    // large timings: wide reset count, longest low time and slot
    set_timing(270, 1, 1, 63, 127, 63, 255);
    push_beat(KIND_RESET, 8'h00);
    finish_op();
    push_beat(KIND_WBIT, 8'h00);
    finish_op();

    random_timing();
    random_beats(100);

    // receiver holds off while the sender keeps pushing
    idle_mode = 2;
    random_timing();
    stall_req = 1'b1;
    random_beats(150);

    // short and long low times beyond the slot length
    set_timing(5, 4, 3, 40, 50, 30, 20);
    random_beats(80);

    wait_drained();
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("one_wire_bus_master test passed");
    end else begin
      $display("one_wire_bus_master test failed");
    end
    $finish;
  end

endmodule
